### hw/rtl/pgpcs_pkg.sv
`timescale 1ns / 1ps

package pgpcs_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DECREASE_STEP   = 3'd0,
        CFG_CONVERGE_WINDOW = 3'd1,
        CFG_SMALL_STEP      = 3'd2,
        CFG_MID_STEP        = 3'd3,
        CFG_LARGE_STEP      = 3'd4,
        CFG_MID_THRESHOLD   = 3'd5,
        CFG_LARGE_THRESHOLD = 3'd6,
        CFG_MIN_POWER       = 3'd7
    } t_cfg_idx;

    // Fill level of the cap history
    typedef enum logic [1:0] {
        HIST_EMPTY = 2'd0,
        HIST_ONE   = 2'd1,
        HIST_FULL  = 2'd2
    } t_hist;

    // Reset values of the configuration registers
    localparam int unsigned RST_DECREASE_STEP   = 800;
    localparam int unsigned RST_CONVERGE_WINDOW = 512;
    localparam int unsigned RST_SMALL_STEP      = 160;
    localparam int unsigned RST_MID_STEP        = 400;
    localparam int unsigned RST_LARGE_STEP      = 800;
    localparam int unsigned RST_MID_THRESHOLD   = 1280;
    localparam int unsigned RST_LARGE_THRESHOLD = 2560;
    localparam int unsigned RST_MIN_POWER       = 1600;

endpackage

### hw/rtl/period_guided_power_cap_stepper.sv
`timescale 1ns / 1ps

// Period-guided power cap stepper. Each input beat carries a node power limit
// (1/16 W) and a freshly measured application period (1/256 s); each one
// yields exactly one output beat with the new power cap and the converged
// flag. The cap comes from a short history: the first beat returns the limit,
// the second the limit minus decrease_step, and from then on the cap steps up
// by small, mid or large step depending on how far the period moved, until
// the period change drops below converge_window. At that point the block
// converges, returns the second-last cap and holds the last cap from then on
// (only reset clears it). Every cap is clamped to [min_power, power_limit];
// the limit wins if min_power exceeds it. Timing: one beat per cycle
// sustained while the output is taken; a beat passes through an input
// register, then the cap update that also writes the history and the output
// register. The history update is a single compare-add-clamp step, so a beat
// may depend on the one right before it with no stall. Write the
// configuration registers only while no beat is in flight.
module period_guided_power_cap_stepper
    import pgpcs_pkg::*;
#(
    parameter int unsigned POWER_BITS  = 16,
    parameter int unsigned PERIOD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Input stream. tdata, low bit up: power_limit, period, zero fill
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    input  logic [((POWER_BITS+PERIOD_BITS+7)/8)*8-1:0]   i_s_tdata,

    // Output stream. tdata, low bit up: new_cap, zero fill
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    output logic [((POWER_BITS+7)/8)*8-1:0]               o_m_tdata,
    // tuser: is_converged
    output logic                                          o_m_tuser,

    // Configuration write channel
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                       i_cfg_index,
    input  logic [((PERIOD_BITS > POWER_BITS) ? PERIOD_BITS : POWER_BITS)-1:0]
                                                          i_cfg_data
);

    localparam int unsigned OUT_BITS = ((POWER_BITS + 7) / 8) * 8;
    // Raw cap: sign bit plus one carry bit above the power width
    localparam int unsigned CAP_BITS = POWER_BITS + 2;

    // Configuration registers
    logic [POWER_BITS-1:0]  r_decrease_step;
    logic [PERIOD_BITS-1:0] r_converge_window;
    logic [POWER_BITS-1:0]  r_small_step;
    logic [POWER_BITS-1:0]  r_mid_step;
    logic [POWER_BITS-1:0]  r_large_step;
    logic [PERIOD_BITS-1:0] r_mid_threshold;
    logic [PERIOD_BITS-1:0] r_large_threshold;
    logic [POWER_BITS-1:0]  r_min_power;

    // Input register
    logic                   r_in_valid;
    logic [POWER_BITS-1:0]  r_limit;
    logic [PERIOD_BITS-1:0] r_period;

    // History
    t_hist                  r_hist;
    logic [POWER_BITS-1:0]  r_last_cap;
    logic [POWER_BITS-1:0]  r_prior_cap;
    logic [PERIOD_BITS-1:0] r_last_period;
    logic                   r_converged;

    // Output register
    logic                   r_out_valid;
    logic [POWER_BITS-1:0]  r_out_cap;
    logic                   r_out_conv;

    logic                   out_free;
    logic                   advance;
    logic                   in_take;
    logic [PERIOD_BITS-1:0] delta;
    logic signed [CAP_BITS-1:0] raw_cap;
    logic signed [CAP_BITS-1:0] min_ext;
    logic signed [CAP_BITS-1:0] limit_ext;
    logic [POWER_BITS-1:0]  n_cap;
    logic                   n_converged;
    t_hist                  n_hist;

    // Output slot frees when empty or taken this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_take    = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; index codes all map to a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrease_step   <= POWER_BITS'(RST_DECREASE_STEP);
            r_converge_window <= PERIOD_BITS'(RST_CONVERGE_WINDOW);
            r_small_step      <= POWER_BITS'(RST_SMALL_STEP);
            r_mid_step        <= POWER_BITS'(RST_MID_STEP);
            r_large_step      <= POWER_BITS'(RST_LARGE_STEP);
            r_mid_threshold   <= PERIOD_BITS'(RST_MID_THRESHOLD);
            r_large_threshold <= PERIOD_BITS'(RST_LARGE_THRESHOLD);
            r_min_power       <= POWER_BITS'(RST_MIN_POWER);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DECREASE_STEP:   r_decrease_step   <= i_cfg_data[POWER_BITS-1:0];
                CFG_CONVERGE_WINDOW: r_converge_window <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_SMALL_STEP:      r_small_step      <= i_cfg_data[POWER_BITS-1:0];
                CFG_MID_STEP:        r_mid_step        <= i_cfg_data[POWER_BITS-1:0];
                CFG_LARGE_STEP:      r_large_step      <= i_cfg_data[POWER_BITS-1:0];
                CFG_MID_THRESHOLD:   r_mid_threshold   <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_LARGE_THRESHOLD: r_large_threshold <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_MIN_POWER:       r_min_power       <= i_cfg_data[POWER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold while the update stage is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_limit  <= i_s_tdata[POWER_BITS-1:0];
            r_period <= i_s_tdata[POWER_BITS +: PERIOD_BITS];
        end
    end

    // Cap selection and clamp
    always_comb begin
        delta = (r_period >= r_last_period) ? (r_period - r_last_period)
                                            : (r_last_period - r_period);
        n_converged = r_converged;
        raw_cap     = '0;
        case (r_hist)
            HIST_EMPTY: begin
                raw_cap = $signed({2'b00, r_limit});
            end
            HIST_ONE: begin
                raw_cap = $signed({2'b00, r_limit}) - $signed({2'b00, r_decrease_step});
            end
            default: begin
                if (r_converged) begin
                    raw_cap = $signed({2'b00, r_last_cap});
                end else if (delta < r_converge_window) begin
                    n_converged = 1'b1;
                    raw_cap     = $signed({2'b00, r_prior_cap});
                end else if (delta < r_mid_threshold) begin
                    raw_cap = $signed({2'b00, r_last_cap}) + $signed({2'b00, r_small_step});
                end else if (delta < r_large_threshold) begin
                    raw_cap = $signed({2'b00, r_last_cap}) + $signed({2'b00, r_mid_step});
                end else begin
                    raw_cap = $signed({2'b00, r_last_cap}) + $signed({2'b00, r_large_step});
                end
            end
        endcase

        // Raise to min_power first, then lower to the limit
        min_ext   = $signed({2'b00, r_min_power});
        limit_ext = $signed({2'b00, r_limit});
        if (raw_cap < min_ext) begin
            raw_cap = min_ext;
        end
        if (raw_cap > limit_ext) begin
            raw_cap = limit_ext;
        end
        n_cap = raw_cap[POWER_BITS-1:0];

        case (r_hist)
            HIST_EMPTY: n_hist = HIST_ONE;
            default:    n_hist = HIST_FULL;
        endcase
    end

    // History update, once per beat leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist        <= HIST_EMPTY;
            r_last_cap    <= '0;
            r_prior_cap   <= '0;
            r_last_period <= '0;
            r_converged   <= 1'b0;
        end else if (advance) begin
            r_hist        <= n_hist;
            r_last_cap    <= n_cap;
            r_prior_cap   <= r_last_cap;
            r_last_period <= r_period;
            r_converged   <= n_converged;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_cap  <= n_cap;
            r_out_conv <= n_converged;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'(r_out_cap);
    assign o_m_tuser  = r_out_conv;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the period-guided power cap stepper.
// Walk the open stimulus rows first, then several random phases, each under
// its own register settings, with the other rows before the last phase.
// Every accepted input beat runs through an in-bench model of the cap policy,
// and every output beat is checked against the oldest expected beat.
module tb;
    import pgpcs_pkg::*;

    localparam int unsigned PWR_W        = 16;
    localparam int unsigned PER_W        = 24;
    localparam int unsigned S_W          = ((PWR_W + PER_W + 7) / 8) * 8;
    localparam int unsigned M_W          = ((PWR_W + 7) / 8) * 8;
    localparam int unsigned CFG_W        = (PER_W > PWR_W) ? PER_W : PWR_W;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned OPEN_ROWS    = 14;

    typedef struct packed {
        logic [15:0] decrease_step;
        logic [23:0] converge_window;
        logic [15:0] small_step;
        logic [15:0] mid_step;
        logic [15:0] large_step;
        logic [23:0] mid_threshold;
        logic [23:0] large_threshold;
        logic [15:0] min_power;
    } t_cap_settings;

    typedef struct packed {
        logic [15:0] cap;
        logic        conv;
    } t_cap_result;

    // One table row: input beat, plus a typed-in result where it is obvious
    typedef struct packed {
        logic [15:0] limit;
        logic [23:0] period;
        logic        typed;
        logic [15:0] cap;
        logic        conv;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [S_W-1:0]   i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [M_W-1:0]   o_m_tdata;
    logic             o_m_tuser;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_DECREASE_STEP;
    logic [CFG_W-1:0] i_cfg_data = '0;

    period_guided_power_cap_stepper #(
        .POWER_BITS  (PWR_W),
        .PERIOD_BITS (PER_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Model copy of the registers and the cap history
    t_cap_settings cfg_now = '{
        decrease_step:   16'(RST_DECREASE_STEP),
        converge_window: 24'(RST_CONVERGE_WINDOW),
        small_step:      16'(RST_SMALL_STEP),
        mid_step:        16'(RST_MID_STEP),
        large_step:      16'(RST_LARGE_STEP),
        mid_threshold:   24'(RST_MID_THRESHOLD),
        large_threshold: 24'(RST_LARGE_THRESHOLD),
        min_power:       16'(RST_MIN_POWER)
    };
    t_hist       hist_fill      = HIST_EMPTY;
    logic [15:0] hist_last_cap  = '0;
    logic [15:0] hist_prior_cap = '0;
    logic [23:0] hist_period    = '0;
    logic        hist_converged = 1'b0;

    t_cap_result cap_expect_q[$];
    int unsigned fail_count   = 0;
    int unsigned stall_cycles = 0;
    int unsigned tx_idle_pct  = 34;
    int unsigned rx_idle_pct  = 73;

    // Directed stimulus. The first OPEN_ROWS rows run under the reset
    // settings and avoid convergence, since the flag is sticky until reset.
    // The rest drive the policy into convergence and then probe that it holds.
    t_stim_row stim_rows[$] = '{
        // empty history: cap is the limit itself
        '{16'hFFFF, 24'h000000, 1'b1, 16'hFFFF, 1'b0},
        // one entry: limit minus step goes negative, limit below min wins
        '{16'h0000, 24'hFFFFFF, 1'b1, 16'h0000, 1'b0},
        // full swing of the period: large step from zero, raised to min
        '{16'hFFFF, 24'h000000, 1'b1, 16'd1600, 1'b0},
        // change equal to mid threshold takes the mid step
        '{16'hFFFF, 24'd1280,   1'b0, 16'h0000, 1'b0},
        // change just below mid threshold takes the small step
        '{16'hFFFF, 24'd2559,   1'b0, 16'h0000, 1'b0},
        // change equal to large threshold takes the large step
        '{16'hFFFF, 24'd5119,   1'b0, 16'h0000, 1'b0},
        // change equal to the window does not converge
        '{16'hFFFF, 24'd4607,   1'b0, 16'h0000, 1'b0},
        // change just below large threshold
        '{16'hFFFF, 24'd7166,   1'b0, 16'h0000, 1'b0},
        // step runs into the limit
        '{16'd3000, 24'd12166,  1'b0, 16'h0000, 1'b0},
        '{16'hFFFF, 24'h000000, 1'b0, 16'h0000, 1'b0},
        // limit below min power
        '{16'd1000, 24'hFFFFFF, 1'b0, 16'h0000, 1'b0},
        '{16'hFFFF, 24'h800000, 1'b0, 16'h0000, 1'b0},
        '{16'h5555, 24'h2AAAAA, 1'b0, 16'h0000, 1'b0},
        '{16'hAAAA, 24'h555555, 1'b0, 16'h0000, 1'b0},
        // settle: same period twice converges and returns the second-last cap
        '{16'd40000, 24'h100000, 1'b0, 16'h0000, 1'b0},
        '{16'd40000, 24'h100000, 1'b0, 16'h0000, 1'b0},
        // sticky: big period swing keeps the last cap
        '{16'hFFFF, 24'h000000, 1'b0, 16'h0000, 1'b0},
        '{16'd1000, 24'hFFFFFF, 1'b1, 16'd1000, 1'b1},
        '{16'hFFFF, 24'h123456, 1'b0, 16'h0000, 1'b0}
    };

    task automatic log_mismatch(input string what);
        if (fail_count < 10) $display("%s", what);
        fail_count++;
    endtask

    // Advance the cap history by one input beat and return the result beat
    task automatic step_cap_policy(input logic [15:0] limit, input logic [23:0] period,
                                   output t_cap_result res);
        int          raw;
        logic [23:0] gap;
        gap = (period >= hist_period) ? period - hist_period : hist_period - period;
        if (hist_fill == HIST_EMPTY) begin
            raw = int'(limit);
        end else if (hist_fill == HIST_ONE) begin
            raw = int'(limit) - int'(cfg_now.decrease_step);
        end else if (hist_converged) begin
            raw = int'(hist_last_cap);
        end else if (gap < cfg_now.converge_window) begin
            hist_converged = 1'b1;
            raw = int'(hist_prior_cap);
        end else if (gap < cfg_now.mid_threshold) begin
            raw = int'(hist_last_cap) + int'(cfg_now.small_step);
        end else if (gap < cfg_now.large_threshold) begin
            raw = int'(hist_last_cap) + int'(cfg_now.mid_step);
        end else begin
            raw = int'(hist_last_cap) + int'(cfg_now.large_step);
        end
        // raise to min first, then cut to the limit so the limit wins
        if (raw < int'(cfg_now.min_power)) raw = int'(cfg_now.min_power);
        if (raw > int'(limit)) raw = int'(limit);
        hist_prior_cap = hist_last_cap;
        hist_last_cap  = raw[15:0];
        hist_period    = period;
        if (hist_fill != HIST_FULL) hist_fill = t_hist'(hist_fill + 2'd1);
        res.cap  = hist_last_cap;
        res.conv = hist_converged;
    endtask

    // Present one input beat, hold it until accepted, then queue its result.
    // Returns on the accepting edge with valid still high.
    task automatic send_beat(input logic [15:0] limit, input logic [23:0] period,
                             input logic typed, input t_cap_result typed_res);
        t_cap_result res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_W'({period, limit});
        do @(posedge i_clk); while (!o_s_tready);
        step_cap_policy(limit, period, res);
        cap_expect_q.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DECREASE_STEP:   cfg_now.decrease_step   = value[15:0];
            CFG_CONVERGE_WINDOW: cfg_now.converge_window = value[23:0];
            CFG_SMALL_STEP:      cfg_now.small_step      = value[15:0];
            CFG_MID_STEP:        cfg_now.mid_step        = value[15:0];
            CFG_LARGE_STEP:      cfg_now.large_step      = value[15:0];
            CFG_MID_THRESHOLD:   cfg_now.mid_threshold   = value[23:0];
            CFG_LARGE_THRESHOLD: cfg_now.large_threshold = value[23:0];
            CFG_MIN_POWER:       cfg_now.min_power       = value[15:0];
            default: ;
        endcase
    endtask

    // Drop the input stream, wait out every result beat, then rewrite all
    // registers. The 16-bit registers get junk in the upper data bits.
    task automatic load_settings(input t_cap_settings s);
        i_s_tvalid <= 1'b0;
        while (cap_expect_q.size() != 0) @(posedge i_clk);
        write_reg(CFG_DECREASE_STEP,   {8'($urandom), s.decrease_step});
        write_reg(CFG_CONVERGE_WINDOW, s.converge_window);
        write_reg(CFG_SMALL_STEP,      {8'($urandom), s.small_step});
        write_reg(CFG_MID_STEP,        {8'($urandom), s.mid_step});
        write_reg(CFG_LARGE_STEP,      {8'($urandom), s.large_step});
        write_reg(CFG_MID_THRESHOLD,   s.mid_threshold);
        write_reg(CFG_LARGE_THRESHOLD, s.large_threshold);
        write_reg(CFG_MIN_POWER,       {8'($urandom), s.min_power});
        i_cfg_valid <= 1'b0;
    endtask

    // Random beats. Most periods move from the last one by a distance aimed
    // at the band edges, so every step size and threshold gets hit.
    task automatic run_random(input int unsigned count);
        int unsigned gap;
        logic        fresh;
        logic [15:0] limit;
        logic [23:0] period;
        for (int unsigned n = 0; n < count; n++) begin
            fresh = 1'b0;
            case ($urandom_range(0, 7))
                0: begin
                    fresh = 1'b1;
                    gap   = $urandom;
                end
                1: gap = cfg_now.mid_threshold;
                2: gap = cfg_now.large_threshold;
                3: gap = cfg_now.mid_threshold - 1;
                4: gap = cfg_now.large_threshold - 1;
                5: gap = cfg_now.converge_window;
                default: gap = $urandom_range(0, cfg_now.large_threshold
                                              + (cfg_now.large_threshold >> 1) + 16);
            endcase
            if (fresh) begin
                period = gap[23:0];
            end else if ($urandom_range(0, 1) == 1) begin
                period = hist_period + gap[23:0];
            end else begin
                period = hist_period - gap[23:0];
            end
            // keep most limits above min power so the steps are visible
            if ($urandom_range(0, 4) == 0) begin
                limit = 16'($urandom);
            end else begin
                limit = 16'($urandom_range(cfg_now.min_power, 16'hFFFF));
            end
            send_beat(limit, period, 1'b0, '0);
        end
    endtask

    // Receiver: stall at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_cap_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cap_expect_q.size() == 0) begin
                log_mismatch($sformatf("unexpected beat: cap %0d converged %0b",
                                       o_m_tdata[15:0], o_m_tuser));
            end else begin
                want = cap_expect_q.pop_front();
                if (o_m_tdata !== M_W'(want.cap) || o_m_tuser !== want.conv) begin
                    log_mismatch($sformatf(
                        "mismatch: cap exp %0d got %0d, converged exp %0b got %0b",
                        want.cap, o_m_tdata[15:0], want.conv, o_m_tuser));
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_cap_settings s;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under reset settings, sender 34 / receiver 73 idle
        for (int r = 0; r < OPEN_ROWS; r++) begin
            send_beat(stim_rows[r].limit, stim_rows[r].period, stim_rows[r].typed,
                      '{stim_rows[r].cap, stim_rows[r].conv});
        end

        // Phase A: zero window keeps the policy from converging; zero min
        s.decrease_step   = 16'h0000;
        s.converge_window = 24'h000000;
        s.small_step      = 16'h0000;
        s.mid_step        = 16'hFFFF;
        s.large_step      = 16'($urandom);
        s.mid_threshold   = 24'($urandom_range(64, 4096));
        s.large_threshold = s.mid_threshold + 24'($urandom_range(0, 8192));
        s.min_power       = 16'h0000;
        load_settings(s);
        run_random(250);

        // Phase B: empty small band, largest decrease and small steps, swap the idling
        tx_idle_pct = 73;
        rx_idle_pct = 34;
        s.decrease_step   = 16'hFFFF;
        s.converge_window = 24'h000000;
        s.small_step      = 16'hFFFF;
        s.mid_step        = 16'($urandom);
        s.large_step      = 16'h0000;
        s.mid_threshold   = 24'h000000;
        s.large_threshold = 24'hFFFFFF;
        s.min_power       = 16'($urandom_range(0, 4000));
        load_settings(s);
        run_random(250);

        // Phase C: thresholds out of order, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        s.decrease_step   = 16'($urandom);
        s.converge_window = 24'h000000;
        s.small_step      = 16'($urandom_range(0, 2000));
        s.mid_step        = 16'($urandom);
        s.large_step      = 16'($urandom);
        s.mid_threshold   = 24'hFFFFFF;
        s.large_threshold = 24'h000000;
        s.min_power       = 16'($urandom_range(0, 20000));
        load_settings(s);
        run_random(150);

        // Back to reset values, then walk the settle and sticky rows
        s.decrease_step   = 16'(RST_DECREASE_STEP);
        s.converge_window = 24'(RST_CONVERGE_WINDOW);
        s.small_step      = 16'(RST_SMALL_STEP);
        s.mid_step        = 16'(RST_MID_STEP);
        s.large_step      = 16'(RST_LARGE_STEP);
        s.mid_threshold   = 24'(RST_MID_THRESHOLD);
        s.large_threshold = 24'(RST_LARGE_THRESHOLD);
        s.min_power       = 16'(RST_MIN_POWER);
        load_settings(s);
        for (int r = OPEN_ROWS; r < stim_rows.size(); r++) begin
            send_beat(stim_rows[r].limit, stim_rows[r].period, stim_rows[r].typed,
                      '{stim_rows[r].cap, stim_rows[r].conv});
        end

        // Phase D: converged for good; widest window and top min power
        s.decrease_step   = 16'($urandom);
        s.converge_window = 24'hFFFFFF;
        s.small_step      = 16'($urandom);
        s.mid_step        = 16'($urandom);
        s.large_step      = 16'($urandom);
        s.mid_threshold   = 24'($urandom);
        s.large_threshold = 24'($urandom);
        s.min_power       = 16'hFFFF;
        load_settings(s);
        run_random(130);

        // Drain: wait for every result, then keep checking for strays
        i_s_tvalid <= 1'b0;
        while (cap_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### period_guided_power_cap_stepper.f
hw/rtl/pgpcs_pkg.sv
hw/rtl/period_guided_power_cap_stepper.sv
tb/sv/tb.sv
